// ----- rtl/dipa_pkg.sv -----
`default_nettype none

package dipa_pkg;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // dots taken before any further character is an error
    localparam logic [2:0] MAX_PARTS = 3'd4;

    // part counts after the open part is closed
    localparam logic [2:0] FORM_A    = 3'd1;
    localparam logic [2:0] FORM_AB   = 3'd2;
    localparam logic [2:0] FORM_ABC  = 3'd3;
    localparam logic [2:0] FORM_ABCD = 3'd4;

    typedef logic [3:0][31:0] part_array_t;

    typedef struct packed {
        logic [31:0] accumulator;
        part_array_t part_values;
        logic [2:0]  parts_done;
        logic        inside_part;
        logic        error_seen;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '0;

endpackage

`default_nettype wire

// ----- rtl/dipa_step.sv -----
`default_nettype none

// One character of parsing plus the end-of-string combine.
module dipa_step
(
    input  wire dipa_pkg::parse_state_t cur,
    input  wire logic [7:0]             char_code,
    input  wire logic                   has_char,
    output dipa_pkg::parse_state_t      nxt,
    output logic [31:0]                 address,
    output logic                        status
);

    logic [3:0]            digit;
    dipa_pkg::part_array_t parts;
    logic [2:0]            count;
    logic [31:0]           combined;
    logic                  bad;

    assign digit = 4'(char_code - dipa_pkg::CHAR_ZERO);

    always_comb
    begin
        nxt = cur;
        if (has_char)
        begin
            priority if (cur.parts_done >= dipa_pkg::MAX_PARTS)
            begin
                nxt.error_seen = 1'b1;
            end
            else if (char_code == dipa_pkg::CHAR_DOT)
            begin
                nxt.part_values[cur.parts_done[1:0]] = cur.accumulator;
                nxt.parts_done  = cur.parts_done + 3'd1;
                nxt.accumulator = '0;
                nxt.inside_part = 1'b0;
            end
            else if (char_code >= dipa_pkg::CHAR_ZERO && char_code <= dipa_pkg::CHAR_NINE)
            begin
                // x*10 as x*8 + x*2, wraps at 32 bits
                nxt.accumulator = (cur.accumulator << 3) + (cur.accumulator << 1)
                                  + {28'd0, digit};
                nxt.inside_part = 1'b1;
            end
            else
            begin
                nxt.error_seen = 1'b1;
            end
        end
    end

    // close the open part, if any
    always_comb
    begin
        parts = nxt.part_values;
        count = nxt.parts_done;
        if (nxt.inside_part && (nxt.parts_done < dipa_pkg::MAX_PARTS))
        begin
            parts[nxt.parts_done[1:0]] = nxt.accumulator;
            count = nxt.parts_done + 3'd1;
        end
    end

    always_comb
    begin
        bad      = nxt.error_seen;
        combined = '0;
        unique case (count)
            dipa_pkg::FORM_A:
                combined = parts[0];
            dipa_pkg::FORM_AB:
                combined = {parts[0][7:0], parts[1][23:0]};
            dipa_pkg::FORM_ABC:
                combined = {parts[0][7:0], parts[1][7:0], parts[2][15:0]};
            dipa_pkg::FORM_ABCD:
                combined = {parts[0][7:0], parts[1][7:0], parts[2][7:0], parts[3][7:0]};
            default:
                bad = 1'b1;   // empty string
        endcase
        address = bad ? 32'd0 : combined;
        status  = bad;
    end

endmodule

`default_nettype wire

// ----- rtl/dotted_ipv4_address_parser.sv -----
// Dotted IPv4 address parser.
//
// Input channel: one request per character (char_code, has_char, is_last),
// taken when in_valid is high and in_stall is low. is_last closes the string;
// has_char = 0 with is_last = 1 ends a string without a character, and
// has_char = 0 with is_last = 0 is ignored.
// Output channel: one request per string (address, status), held on the
// ports while out_valid is high and out_stall is high.
// Timing: a request is held in the input register and applied to the parse
// state as it leaves; a string's result is registered for out_valid as its
// last request leaves. One request per cycle is taken unless a last one waits;
// the per-character path is one shift-add (x*10 + digit) and the combine mux.
// Stall: only a last request waits, and only while a result is still held on
// a stalled output; other characters keep flowing into the state.
// Reset: clears the input and output valids and the parse state; the first
// request after reset starts a new string.
`default_nettype none

module dotted_ipv4_address_parser
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        has_char,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      address,
    output logic             status
);

    // input register
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_char_reg;
    logic        s1_has_reg;
    logic        s1_last_reg;

    // parse state of the string in progress
    dipa_pkg::parse_state_t state_reg, state_next;
    dipa_pkg::parse_state_t step_state;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] address_reg;
    logic        status_reg;

    logic [31:0] step_address;
    logic        step_status;
    logic        out_free;
    logic        consume;
    logic        load;

    dipa_step u_step
    (
        .cur       (state_reg),
        .char_code (s1_char_reg),
        .has_char  (s1_has_reg),
        .nxt       (step_state),
        .address   (step_address),
        .status    (step_status)
    );

    assign out_free = !out_valid_reg || !out_stall;
    // a last character needs a free result slot; others never wait
    assign consume  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !consume;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (consume)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (consume)
        begin
            state_next = s1_last_reg ? dipa_pkg::STATE_CLEAR : step_state;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (consume && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= dipa_pkg::STATE_CLEAR;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_char_reg <= char_code;
            s1_has_reg  <= has_char;
            s1_last_reg <= is_last;
        end
        if (consume && s1_last_reg)
        begin
            address_reg <= step_address;
            status_reg  <= step_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign address   = address_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ----- rtl/dipa_checker.sv -----
`default_nettype none

module dipa_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] address,
    input wire logic        status
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(address) && $stable(status))
        else $error("result changed while stalled");

    // an invalid string reports address zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> address == 32'd0)
        else $error("invalid result with nonzero address");

    // input only waits behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // reset empties the output
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind dotted_ipv4_address_parser dipa_checker u_dipa_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .address   (address),
    .status    (status)
);

`default_nettype wire
